[rtl/hstm_pkg.sv]
// hstm_pkg: shared types and constants for the heater settling test monitor.
// Used by every module of the block and by its checker.
`default_nettype none

package hstm_pkg;

   localparam int TEMP_W     = 14;
   localparam int TGT_W      = 13;
   localparam int HEATER_W   = 4;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 112;

   // command codes on req_tuser
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // result kinds on rsp_tuser
   localparam logic [1:0] KIND_SETPOINT = 2'd0;
   localparam logic [1:0] KIND_REPORT   = 2'd1;
   localparam logic [1:0] KIND_BUSY     = 2'd2;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_TOLERANCE = 2'd0;
   localparam logic [1:0] REG_COOL_LIMIT = 2'd1;
   localparam logic [1:0] REG_INTERVAL  = 2'd2;

   localparam logic [TGT_W-1:0]      TOLERANCE_RESET  = 13'd16;
   localparam logic [TGT_W-1:0]      COOL_LIMIT_RESET = 13'd640;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 16'd30;

   // test phases
   localparam logic [1:0] PHASE_COOL   = 2'd0;
   localparam logic [1:0] PHASE_HEAT   = 2'd1;
   localparam logic [1:0] PHASE_SETTLE = 2'd2;

   // response tdata layout, lowest field first
   localparam int RSP_SETPOINT_LSB = 0;
   localparam int RSP_HEATER_LSB   = RSP_SETPOINT_LSB + TGT_W;
   localparam int RSP_STABLE_LSB   = RSP_HEATER_LSB + HEATER_W;
   localparam int RSP_PEAK_LSB     = RSP_STABLE_LSB + TEMP_W;
   localparam int RSP_STAB_LSB     = RSP_PEAK_LSB + TEMP_W;
   localparam int RSP_REACH_LSB    = RSP_STAB_LSB + TIME_W;
   localparam int RSP_USED_W       = RSP_REACH_LSB + TIME_W;

   typedef struct packed {
      logic [TGT_W-1:0]      tolerance;
      logic [TGT_W-1:0]      cool_limit;
      logic [INTERVAL_W-1:0] interval;
   } cfg_type;

   typedef enum logic [2:0] {
      OUT_SP_ZERO,
      OUT_SP_TARGET,
      OUT_BUSY,
      OUT_CANCEL,
      OUT_DONE
   } out_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        start;
      logic        store_sample;
      logic        stamp_settle;
      logic        scan_start;
      logic        scan_step;
      logic        calc_diff;
      logic        calc_final;
      logic        load_out;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       above_limit;
      logic       above_target;
      logic       window_full;
      logic       scan_done;
      logic       stable;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/heater_settling_test_monitor_core.sv]
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: command; tdata: temp, target, heater, time
// rsp       out  rsp_tvalid/rsp_tready  tuser: kind; tdata: setpoint .. time_to_reach
// csr       in   csr_psel/csr_penable   APB-style, pready tied high
//
// A start or busy goes from acceptance through EXEC to EMIT and the result load; a
// cancel also passes DIFF and FINAL. An unknown command or a tick without a completion
// check returns from EXEC to idle; a tick that ends cool-down and commands the target
// goes on to EMIT. A tick in stabilization walks the window memory through its single
// read port, then with a report passes DIFF and FINAL to EMIT. Reset is synchronous
// and needs no clearing pass. A result waiting on rsp_tready does not block acceptance
// of the next item; only the next result load waits for it.
//
// Top level of the heater settling test monitor; depends on hstm_pkg, hstm_csr,
// hstm_dp and hstm_ctrl.
`default_nettype none

module heater_settling_test_monitor_core
   import hstm_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [13:0] temperature, [26:14] target_temperature, [30:27] heater_index,
   // [62:31] time_now, [63] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [12:0] setpoint, [16:13] report_heater, [30:17] stable_temperature,
   // [44:31] peak_temperature, [76:45] stab_time, [108:77] time_to_reach,
   // [111:109] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] kind
   output logic      [1:0]            rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   hstm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   hstm_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   hstm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

endmodule

`default_nettype wire

[rtl/hstm_csr.sv]
// hstm_csr: APB-style register file for tolerance, cool-down limit and interval.
// Depends on hstm_pkg.
`default_nettype none

module hstm_csr
   import hstm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TOLERANCE:  cfg_in.tolerance  = pwdata[TGT_W-1:0];
            REG_COOL_LIMIT: cfg_in.cool_limit = pwdata[TGT_W-1:0];
            REG_INTERVAL:   cfg_in.interval   = pwdata[INTERVAL_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TOLERANCE:  prdata = {{(CSR_DATA_W-TGT_W){1'b0}}, cfg_ff.tolerance};
         REG_COOL_LIMIT: prdata = {{(CSR_DATA_W-TGT_W){1'b0}}, cfg_ff.cool_limit};
         REG_INTERVAL:   prdata = {{(CSR_DATA_W-INTERVAL_W){1'b0}}, cfg_ff.interval};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance  <= TOLERANCE_RESET;
         cfg_ff.cool_limit <= COOL_LIMIT_RESET;
         cfg_ff.interval   <= INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/hstm_dp.sv]
// hstm_dp: datapath - held item, test state, sample window memory, min/max walk,
// time arithmetic and result register. Depends on hstm_pkg.
`default_nettype none

module hstm_dp
   import hstm_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire cfg_type               cfg,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [1:0]            rsp_tuser
);

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FW = $clog2(WINDOW + 1);

   // held item
   logic        [1:0]          item_cmd_ff;
   logic signed [TEMP_W-1:0]   item_temp_ff;
   logic        [TGT_W-1:0]    item_tgt_ff;
   logic        [HEATER_W-1:0] item_heater_ff;
   logic        [TIME_W-1:0]   item_now_ff;

   // test state
   logic        [AW-1:0]       slot_ff;
   logic        [FW-1:0]       fill_ff;
   logic signed [TEMP_W-1:0]   peak_ff;
   logic        [TGT_W-1:0]    target_ff;
   logic        [HEATER_W-1:0] heater_ff;
   logic        [TIME_W-1:0]   start_stamp_ff;
   logic        [TIME_W-1:0]   settle_stamp_ff;

   // window walk
   logic signed [TEMP_W-1:0]   window_mem [WINDOW];
   logic        [FW-1:0]       scan_cnt_ff;
   logic                       rd_valid_ff;
   logic                       rd_first_ff;
   logic signed [TEMP_W-1:0]   rd_data_ff;
   logic signed [TEMP_W-1:0]   hi_ff;
   logic signed [TEMP_W-1:0]   lo_ff;
   logic                       rd_issue;
   logic        [TEMP_W:0]     spread;

   // times
   logic        [TIME_W:0]     diff_ff;
   logic        [TIME_W:0]     reach_ff;
   logic        [TIME_W+1:0]   stab_ff;

   // result register
   logic        [1:0]          out_kind_ff;
   logic        [TGT_W-1:0]    out_sp_ff;
   logic        [HEATER_W-1:0] out_heater_ff;
   logic        [TEMP_W-1:0]   out_stable_ff;
   logic        [TEMP_W-1:0]   out_peak_ff;
   logic        [TIME_W-1:0]   out_stab_ff;
   logic        [TIME_W-1:0]   out_reach_ff;
   logic        [TIME_W-1:0]   stab_clamped;
   logic        [TIME_W-1:0]   reach_clamped;

   assign rd_issue = cmd.scan_step && (scan_cnt_ff != FW'(WINDOW));
   assign spread   = {hi_ff[TEMP_W-1], hi_ff} - {lo_ff[TEMP_W-1], lo_ff};

   assign status.command      = item_cmd_ff;
   assign status.above_limit  = item_temp_ff > $signed({1'b0, cfg.cool_limit});
   assign status.above_target = item_temp_ff > $signed({1'b0, target_ff});
   assign status.window_full  = (fill_ff == FW'(WINDOW));
   assign status.scan_done    = (scan_cnt_ff == FW'(WINDOW)) && !rd_valid_ff;
   assign status.stable       = spread < {2'b00, cfg.tolerance};

   assign stab_clamped  = stab_ff[TIME_W+1] ? '0 : stab_ff[TIME_W-1:0];
   assign reach_clamped = reach_ff[TIME_W]  ? '0 : reach_ff[TIME_W-1:0];

   assign rsp_tuser = out_kind_ff;
   assign rsp_tdata = {{(RSP_DATA_W-RSP_USED_W){1'b0}}, out_reach_ff, out_stab_ff,
                       out_peak_ff, out_stable_ff, out_heater_ff, out_sp_ff};

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_cmd_ff    <= req_tuser;
         item_temp_ff   <= req_tdata[TEMP_W-1:0];
         item_tgt_ff    <= req_tdata[TEMP_W +: TGT_W];
         item_heater_ff <= req_tdata[TEMP_W+TGT_W +: HEATER_W];
         item_now_ff    <= req_tdata[TEMP_W+TGT_W+HEATER_W +: TIME_W];
      end
   end

   // test state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff         <= '0;
         fill_ff         <= '0;
         peak_ff         <= '0;
         target_ff       <= '0;
         heater_ff       <= '0;
         start_stamp_ff  <= '0;
         settle_stamp_ff <= '0;
      end else begin
         if (cmd.start) begin
            slot_ff        <= '0;
            fill_ff        <= '0;
            peak_ff        <= '0;
            target_ff      <= item_tgt_ff;
            heater_ff      <= item_heater_ff;
            start_stamp_ff <= item_now_ff;
         end else if (cmd.store_sample) begin
            slot_ff <= (slot_ff == AW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (fill_ff != FW'(WINDOW)) begin
               fill_ff <= fill_ff + 1'b1;
            end
            if (item_temp_ff > peak_ff) begin
               peak_ff <= item_temp_ff;
            end
         end
         if (cmd.stamp_settle) begin
            settle_stamp_ff <= item_now_ff;
         end
      end
   end

   // sample window: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_sample) begin
         window_mem[slot_ff] <= item_temp_ff;
      end
      if (rd_issue) begin
         rd_data_ff <= window_mem[scan_cnt_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         rd_valid_ff <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_issue;
         rd_first_ff <= (scan_cnt_ff == '0);
         if (cmd.scan_start) begin
            scan_cnt_ff <= '0;
         end else if (rd_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         if (rd_first_ff || rd_data_ff > hi_ff) begin
            hi_ff <= rd_data_ff;
         end
         if (rd_first_ff || rd_data_ff < lo_ff) begin
            lo_ff <= rd_data_ff;
         end
      end
   end

   // time arithmetic over two steps
   always_ff @(posedge clock) begin
      if (cmd.calc_diff) begin
         diff_ff  <= {1'b0, item_now_ff} - {1'b0, settle_stamp_ff};
         reach_ff <= {1'b0, settle_stamp_ff} - {1'b0, start_stamp_ff};
      end
      if (cmd.calc_final) begin
         stab_ff <= {diff_ff[TIME_W], diff_ff}
                    - {{(TIME_W+2-INTERVAL_W){1'b0}}, cfg.interval};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_heater_ff <= heater_ff;
         out_sp_ff     <= '0;
         out_stable_ff <= '0;
         out_peak_ff   <= '0;
         out_stab_ff   <= '0;
         out_reach_ff  <= '0;
         case (cmd.out_sel)
            OUT_SP_ZERO: begin
               out_kind_ff <= KIND_SETPOINT;
            end
            OUT_SP_TARGET: begin
               out_kind_ff <= KIND_SETPOINT;
               out_sp_ff   <= target_ff;
            end
            OUT_BUSY: begin
               out_kind_ff <= KIND_BUSY;
            end
            OUT_CANCEL: begin
               out_kind_ff  <= KIND_REPORT;
               out_peak_ff  <= peak_ff;
               out_stab_ff  <= stab_clamped;
               out_reach_ff <= reach_clamped;
            end
            OUT_DONE: begin
               out_kind_ff   <= KIND_REPORT;
               out_stable_ff <= item_temp_ff;
               out_peak_ff   <= peak_ff;
               out_stab_ff   <= stab_clamped;
               out_reach_ff  <= reach_clamped;
            end
            default: begin
               out_kind_ff <= KIND_BUSY;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/hstm_ctrl.sv]
// hstm_ctrl: sequencer for the test monitor; owns running flag, phase and
// result valid. Drives hstm_dp through command/status structs from hstm_pkg.
`default_nettype none

module hstm_ctrl
   import hstm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DIFF,
      ST_FINAL,
      ST_EMIT
   } state_type;

   state_type   state_ff,     state_in;
   logic        running_ff,   running_in;
   logic [1:0]  phase_ff,     phase_in;
   out_sel_type out_sel_ff,   out_sel_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  eff_phase;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   // a tick that ends cooling is handled as heating from then on
   assign eff_phase  = (phase_ff == PHASE_COOL) ? PHASE_HEAT : phase_ff;

   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      phase_in     = phase_ff;
      out_sel_in   = out_sel_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.out_sel  = out_sel_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.command)
               CMD_START: begin
                  state_in = ST_EMIT;
                  if (running_ff) begin
                     out_sel_in = OUT_BUSY;
                  end else begin
                     cmd.start  = 1'b1;
                     running_in = 1'b1;
                     if (status.above_limit) begin
                        phase_in   = PHASE_COOL;
                        out_sel_in = OUT_SP_ZERO;
                     end else begin
                        phase_in   = PHASE_HEAT;
                        out_sel_in = OUT_SP_TARGET;
                     end
                  end
               end
               CMD_CANCEL: begin
                  running_in = 1'b0;
                  out_sel_in = OUT_CANCEL;
                  state_in   = ST_DIFF;
               end
               CMD_TICK: begin
                  state_in = ST_IDLE;
                  if (running_ff && !(phase_ff == PHASE_COOL && status.above_limit)) begin
                     cmd.store_sample = 1'b1;
                     if (phase_ff == PHASE_COOL) begin
                        phase_in   = PHASE_HEAT;
                        out_sel_in = OUT_SP_TARGET;
                        state_in   = ST_EMIT;
                     end
                     if (status.window_full) begin
                        if (eff_phase == PHASE_HEAT) begin
                           if (status.above_target) begin
                              phase_in         = PHASE_SETTLE;
                              cmd.stamp_settle = 1'b1;
                           end
                        end else begin
                           cmd.scan_start = 1'b1;
                           state_in       = ST_SCAN;
                        end
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               if (status.stable) begin
                  running_in = 1'b0;
                  out_sel_in = OUT_DONE;
                  state_in   = ST_DIFF;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.calc_final = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         phase_ff     <= PHASE_COOL;
         out_sel_ff   <= OUT_SP_ZERO;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         phase_ff     <= phase_in;
         out_sel_ff   <= out_sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/hstm_check.sv]
// hstm_check: port-level checks on the result channel of the test monitor,
// bound to heater_settling_test_monitor_core. Depends on hstm_pkg.
`default_nettype none

module hstm_check
   import hstm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == KIND_SETPOINT || rsp_tuser == KIND_REPORT
                     || rsp_tuser == KIND_BUSY)
      else $error("result kind out of range");

   // only reports carry temperatures and times
   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_REPORT
      |-> rsp_tdata[RSP_USED_W-1:RSP_STABLE_LSB] == '0)
      else $error("setpoint or busy transaction carries report fields");

   // only setpoint results carry a setpoint
   a_setpoint_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_SETPOINT
      |-> rsp_tdata[RSP_HEATER_LSB-1:RSP_SETPOINT_LSB] == '0)
      else $error("non-setpoint transaction carries a setpoint");

endmodule

bind heater_settling_test_monitor_core hstm_check u_hstm_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[sim/hstm_checker.sv]
// Checker for heater_settling_test_monitor_core: watches the request, result and
// register ports, predicts every result and compares it. Depends on hstm_pkg.
module hstm_checker
   import hstm_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [1:0]            rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                  csr_pready,
   output int                         errors,
   output int                         pending,
   output int                         results_total
);

   typedef struct packed {
      logic [1:0]               kind;
      logic [TGT_W-1:0]         setpoint;
      logic [HEATER_W-1:0]      heater;
      logic signed [TEMP_W-1:0] stable;
      logic signed [TEMP_W-1:0] peak;
      logic [TIME_W-1:0]        stab_time;
      logic [TIME_W-1:0]        reach_time;
   } outcome_type;

   outcome_type              due_q[$];

   logic [TGT_W-1:0]         tol_cfg;
   logic [TGT_W-1:0]         limit_cfg;
   logic [INTERVAL_W-1:0]    interval_cfg;

   logic                     active;
   logic [1:0]               test_phase;
   logic signed [TEMP_W-1:0] samples [WINDOW];
   int                       slot;
   int                       filled;
   logic signed [TEMP_W-1:0] peak;
   logic [TGT_W-1:0]         target;
   logic [HEATER_W-1:0]      heater;
   logic [TIME_W-1:0]        start_time;
   logic [TIME_W-1:0]        settle_time;

   function automatic outcome_type test_report(input logic signed [TEMP_W-1:0] stable,
                                               input logic [TIME_W-1:0] now);
      outcome_type r;
      longint      t_now, t_settle, t_start, t_ivl, lag, rise;
      t_now    = now;
      t_settle = settle_time;
      t_start  = start_time;
      t_ivl    = interval_cfg;
      lag      = t_now - t_settle - t_ivl;
      rise     = t_settle - t_start;
      r = '0;
      r.kind       = KIND_REPORT;
      r.heater     = heater;
      r.stable     = stable;
      r.peak       = peak;
      r.stab_time  = (lag > 0) ? lag[31:0] : '0;
      r.reach_time = (rise > 0) ? rise[31:0] : '0;
      return r;
   endfunction

   task automatic track_item(input logic [1:0] cmd, input logic signed [TEMP_W-1:0] temp,
                             input logic [TGT_W-1:0] tgt, input logic [HEATER_W-1:0] hid,
                             input logic [TIME_W-1:0] now);
      outcome_type r;
      int          t, lim, goal, tol, hi, lo;
      bit          emit, cooling;
      r       = '0;
      emit    = 1'b0;
      cooling = 1'b0;
      t       = temp;
      lim     = limit_cfg;
      tol     = tol_cfg;
      case (cmd)
         CMD_START: begin
            if (active) begin
               r.kind   = KIND_BUSY;
               r.heater = heater;
            end else begin
               start_time = now;
               target     = tgt;
               heater     = hid;
               slot       = 0;
               filled     = 0;
               peak       = '0;
               active     = 1'b1;
               r.kind     = KIND_SETPOINT;
               r.heater   = hid;
               if (t > lim) begin
                  test_phase = PHASE_COOL;
               end else begin
                  test_phase = PHASE_HEAT;
                  r.setpoint = tgt;
               end
            end
            emit = 1'b1;
         end
         CMD_CANCEL: begin
            active = 1'b0;
            r      = test_report('0, now);
            emit   = 1'b1;
         end
         CMD_TICK: if (active) begin
            if (test_phase == PHASE_COOL) begin
               if (t > lim) begin
                  cooling = 1'b1;
               end else begin
                  // leaving cool-down commands the target; the sample is still stored
                  test_phase = PHASE_HEAT;
                  r.kind     = KIND_SETPOINT;
                  r.setpoint = target;
                  r.heater   = heater;
                  emit       = 1'b1;
               end
            end
            if (!cooling) begin
               samples[slot] = temp;
               slot = (slot + 1) % WINDOW;
               if (temp > peak) peak = temp;
               if (filled < WINDOW) begin
                  filled++;
               end else if (test_phase == PHASE_HEAT) begin
                  goal = target;
                  if (t > goal) begin
                     test_phase  = PHASE_SETTLE;
                     settle_time = now;
                  end
               end else begin
                  hi = samples[0];
                  lo = samples[0];
                  for (int i = 1; i < WINDOW; i++) begin
                     if (samples[i] > hi) hi = samples[i];
                     if (samples[i] < lo) lo = samples[i];
                  end
                  if (hi - lo < tol) begin
                     active = 1'b0;
                     r      = test_report(samples[(slot + WINDOW - 1) % WINDOW], now);
                     emit   = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      if (emit) begin
         due_q.push_back(r);
         results_total++;
      end
   endtask

   task automatic note_error(input string msg);
      if (errors < 10) $display("%0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      outcome_type      got, want;
      logic [31:0]      reg_val;
      if (reset) begin
         due_q.delete();
         errors        = 0;
         results_total = 0;
         tol_cfg       = TOLERANCE_RESET;
         limit_cfg     = COOL_LIMIT_RESET;
         interval_cfg  = INTERVAL_RESET;
         active        = 1'b0;
         test_phase    = PHASE_COOL;
         slot          = 0;
         filled        = 0;
         peak          = '0;
         target        = '0;
         heater        = '0;
         start_time    = '0;
         settle_time   = '0;
         for (int i = 0; i < WINDOW; i++) samples[i] = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_paddr[3:2])
               REG_TOLERANCE:  reg_val = {19'd0, tol_cfg};
               REG_COOL_LIMIT: reg_val = {19'd0, limit_cfg};
               REG_INTERVAL:   reg_val = {16'd0, interval_cfg};
               default:        reg_val = '0;
            endcase
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_TOLERANCE:  tol_cfg      = csr_pwdata[TGT_W-1:0];
                  REG_COOL_LIMIT: limit_cfg    = csr_pwdata[TGT_W-1:0];
                  REG_INTERVAL:   interval_cfg = csr_pwdata[INTERVAL_W-1:0];
                  default: ;
               endcase
            end else if (csr_prdata !== reg_val) begin
               note_error($sformatf("register read at %0d: expected %0d, got %0d",
                                    csr_paddr, reg_val, csr_prdata));
            end
         end
         if (req_tvalid && req_tready)
            track_item(req_tuser, req_tdata[0 +: TEMP_W], req_tdata[14 +: TGT_W],
                       req_tdata[27 +: HEATER_W], req_tdata[31 +: TIME_W]);
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = rsp_tuser;
            got.setpoint   = rsp_tdata[RSP_SETPOINT_LSB +: TGT_W];
            got.heater     = rsp_tdata[RSP_HEATER_LSB +: HEATER_W];
            got.stable     = rsp_tdata[RSP_STABLE_LSB +: TEMP_W];
            got.peak       = rsp_tdata[RSP_PEAK_LSB +: TEMP_W];
            got.stab_time  = rsp_tdata[RSP_STAB_LSB +: TIME_W];
            got.reach_time = rsp_tdata[RSP_REACH_LSB +: TIME_W];
            if (due_q.size() == 0) begin
               note_error($sformatf("unexpected result transaction, kind %0d", got.kind));
            end else begin
               want = due_q.pop_front();
               if (got !== want)
                  note_error($sformatf({"result mismatch\n",
                     "  expected kind %0d sp %0d heater %0d stable %0d peak %0d",
                     " t_stab %0d t_reach %0d\n",
                     "  actual   kind %0d sp %0d heater %0d stable %0d peak %0d",
                     " t_stab %0d t_reach %0d"},
                     want.kind, want.setpoint, want.heater, want.stable, want.peak,
                     want.stab_time, want.reach_time,
                     got.kind, got.setpoint, got.heater, got.stable, got.peak,
                     got.stab_time, got.reach_time));
            end
         end
      end
      pending = due_q.size();
   end

endmodule

[sim/heater_settling_test_monitor_core_tb.sv]
// Testbench top for heater_settling_test_monitor_core: drives commands, ticks and
// register writes, and gives the verdict. Depends on hstm_pkg and hstm_checker.
module heater_settling_test_monitor_core_tb;
   import hstm_pkg::*;

   localparam int         WINDOW      = 64;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [1:0]            req_tuser   = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    errors;
   int                    pending;
   int                    results_total;

   bit                    calm        = 1'b0;
   int                    items       = 0;
   logic [TIME_W-1:0]     uptime      = '0;
   int                    cfg_tol     = TOLERANCE_RESET;
   int                    cfg_limit   = COOL_LIMIT_RESET;

   heater_settling_test_monitor_core #(.WINDOW(WINDOW)) uut (.*);

   hstm_checker #(.WINDOW(WINDOW)) chk (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= 26);

   initial begin
      #2_500_000;
      $display("heater_settling_test_monitor_core verification failed");
      $finish;
   end

   function automatic int temp_in(input int lo, input int hi);
      int v;
      v = $urandom_range(0, hi - lo);
      return lo + v;
   endfunction

   task automatic send(input logic [1:0] cmd, input int temp, input int tgt, input int hid,
                       input logic [TIME_W-1:0] now);
      logic [TEMP_W-1:0]   t14;
      logic [TGT_W-1:0]    g;
      logic [HEATER_W-1:0] h;
      t14 = temp[TEMP_W-1:0];
      g   = tgt[TGT_W-1:0];
      h   = hid[HEATER_W-1:0];
      while (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, now, h, g, t14};
      do @(posedge clock); while (!req_tready);
      items++;
   endtask

   task automatic send_noise(input logic [1:0] cmd);
      send(cmd, temp_in(-8192, 8191), $urandom_range(0, 8191), $urandom_range(0, 15),
           $urandom());
   endtask

   // tick with the odd busy start or unknown command slipped in
   task automatic tick(input int temp);
      int r;
      r = $urandom_range(99);
      if (r < 2) send_noise(CMD_START);
      else if (r < 4) send_noise(CMD_UNUSED);
      if ($urandom_range(99) == 0) uptime = $urandom();
      else uptime += $urandom_range(1, 3);
      send(CMD_TICK, temp, $urandom_range(0, 8191), $urandom_range(0, 15), uptime);
   endtask

   task automatic csr_access(input bit wr, input logic [1:0] idx, input int val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic read_back();
      csr_access(1'b0, REG_TOLERANCE, 0);
      csr_access(1'b0, REG_COOL_LIMIT, 0);
      csr_access(1'b0, REG_INTERVAL, 0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int tol, input int lim, input int ivl);
      csr_access(1'b1, REG_TOLERANCE, tol);
      csr_access(1'b1, REG_COOL_LIMIT, lim);
      csr_access(1'b1, REG_INTERVAL, ivl);
      read_back();
      cfg_tol   = tol;
      cfg_limit = lim;
   endtask

   // waits out every expected result, then the longest tick that makes none
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (WINDOW + 16) @(posedge clock);
   endtask

   // start, optional cool-down, window fill, crossing, settling band, optional cancel
   task automatic full_test();
      int tgt, hid, band, lvl, top;
      tgt = $urandom_range(0, 7900);
      hid = $urandom_range(0, 15);
      uptime += $urandom_range(1, 5);
      if (cfg_limit < 8191 && $urandom_range(1)) begin
         send(CMD_START, temp_in(cfg_limit + 1, 8191), tgt, hid, uptime);
         repeat ($urandom_range(0, 3)) tick(temp_in(cfg_limit + 1, 8191));
         tick(temp_in(-8192, cfg_limit));
      end else begin
         send(CMD_START, temp_in(-8192, cfg_limit), tgt, hid, uptime);
      end
      repeat (WINDOW) tick($urandom_range(1) ? temp_in(-8192, 8191) : temp_in(tgt - 200, tgt));
      repeat ($urandom_range(0, 3)) tick(temp_in(tgt - 400, tgt));
      band = (cfg_tol > 1) ? $urandom_range(0, (cfg_tol - 1 < 250) ? cfg_tol - 1 : 250) : 0;
      top  = (tgt + 300 < 8191 - band) ? tgt + 300 : 8191 - band;
      lvl  = temp_in(tgt + 1, top);
      repeat (WINDOW + $urandom_range(0, 6)) tick(temp_in(lvl, lvl + band));
      if (cfg_tol == 0 || $urandom_range(2) == 0)
         send(CMD_CANCEL, temp_in(-8192, 8191), 0, 0, uptime + $urandom_range(0, 100));
   endtask

   task automatic short_test();
      send(CMD_START, temp_in(-8192, 8191), $urandom_range(0, 8191), $urandom_range(0, 15),
           $urandom());
      repeat ($urandom_range(0, 5)) tick(temp_in(-8192, 8191));
      if ($urandom_range(1)) send_noise(CMD_START);
      send_noise(CMD_CANCEL);
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(3, 10)) send_noise(2'($urandom_range(0, 3)));
      send_noise(CMD_CANCEL);
   endtask

   initial begin
      int ph, r, tol, lim, ivl;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back();

      // directed: idle tick, unknown command, cancel while idle
      send(CMD_TICK, 100, 0, 0, 5);
      send(CMD_UNUSED, 0, 0, 0, 6);
      send(CMD_CANCEL, 0, 0, 0, 32'hFFFF_FFFF);
      // start above the limit cools first; a second start is busy
      send(CMD_START, 8191, 8191, 15, 0);
      send(CMD_START, -8192, 0, 0, 1);
      send(CMD_TICK, 641, 0, 0, 2);
      send(CMD_TICK, 640, 8191, 15, 3);
      send(CMD_TICK, -8192, 0, 0, 4);
      // cancel before stabilization uses the old settle stamp
      send(CMD_CANCEL, 0, 0, 0, 7);
      send(CMD_START, -8192, 0, 0, 32'hFFFF_FFFF);
      send(CMD_TICK, 8191, 0, 0, 32'hFFFF_FFFF);
      send(CMD_TICK, -1, 0, 0, 0);
      send(CMD_CANCEL, 0, 0, 0, 0);
      uptime = $urandom();

      ph = 0;
      while (items < 1000) begin
         drain();
         ph++;
         calm = (ph == 2);
         case (ph)
            1: set_config(8191, 0, 65535);
            2: set_config(0, 8191, 0);
            default: begin
               r   = $urandom_range(9);
               tol = (r == 0) ? 0 : (r == 1) ? 8191 : (r == 2) ? 1 : $urandom_range(2, 300);
               r   = $urandom_range(9);
               lim = (r == 0) ? 0 : (r == 1) ? 8191 : $urandom_range(0, 2000);
               r   = $urandom_range(9);
               ivl = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 200);
               set_config(tol, lim, ivl);
            end
         endcase
         repeat (3) begin
            r = $urandom_range(99);
            if (r < 55) full_test();
            else if (r < 80) short_test();
            else noise_burst();
         end
      end
      calm = 1'b0;
      drain();

      if (errors == 0 && pending == 0)
         $display("heater_settling_test_monitor_core verification clean");
      else
         $display("heater_settling_test_monitor_core verification failed");
      $finish;
   end

endmodule

[files.f]
rtl/hstm_pkg.sv
rtl/hstm_csr.sv
rtl/hstm_dp.sv
rtl/hstm_ctrl.sv
rtl/heater_settling_test_monitor_core.sv
rtl/hstm_check.sv
sim/hstm_checker.sv
sim/heater_settling_test_monitor_core_tb.sv
